FILE: hw/rtl/word_lexer_with_comments_assert.svh
// Assertion macros for the word lexer.
`ifndef WORD_LEXER_WITH_COMMENTS_ASSERT_SVH
`define WORD_LEXER_WITH_COMMENTS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("word lexer check failed");
// next-cycle implication
`define WLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("word lexer check failed");
`else
`define WLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/wlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wlc_pkg;

    localparam int WLC_LENGTH_LIMIT  = 256;
    localparam int WLC_POSITION_BITS = 32;
    localparam int WLC_QUEUE_DEPTH   = 4;
    localparam logic [8:0] WLC_MAX_LEN_RESET = 9'd64;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        KIND_CHAR   = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_BADCOM = 3'd2,
        KIND_LONG   = 3'd3,
        KIND_NOWORD = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        PH_NORMAL = 5'b00001,
        PH_SLASH  = 5'b00010,
        PH_BLOCK  = 5'b00100,
        PH_BSTAR  = 5'b01000,
        PH_LINE   = 5'b10000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [8:0]  len;
        logic [31:0] pos;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

FILE: hw/rtl/wlc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wlc_front
    import wlc_pkg::*;
#(
    parameter int POSITION_BITS = WLC_POSITION_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    input  wire  [8:0]  i_cfg_data,
    input  wire         i_valid,
    input  wire  [7:0]  i_byte,
    input  wire         i_eoi,
    input  t_q_status   i_q_status,
    output logic        o_ready,
    output logic        o_push,
    output t_res        o_res
);

    localparam logic [16:0] LimitMax = 17'(WLC_LENGTH_LIMIT);

    logic [8:0]               r_max_len;
    t_phase                   r_phase, n_phase;
    logic                     r_started, n_started;
    logic [8:0]               r_count, n_count;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic        w_accept;
    logic [16:0] w_limit;
    logic        w_fits;
    logic        w_space;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    // effective buffer size is the register clamped to the hard limit
    assign w_limit = (17'(r_max_len) > LimitMax) ? LimitMax : 17'(r_max_len);
    assign w_fits  = (w_limit >= 17'd2) && (17'(r_count) < (w_limit - 17'd1));
    assign w_space = i_byte inside {CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_CR};

    always_comb begin
        n_phase   = r_phase;
        n_started = r_started;
        n_count   = r_count;
        n_pos     = r_pos;
        o_push    = 1'b0;
        o_res.kind = KIND_CHAR;
        o_res.ch   = 8'd0;
        o_res.len  = r_count;
        o_res.pos  = 32'(r_pos);
        if (w_accept) begin
            if (i_eoi) begin
                o_push = 1'b1;
                if (r_phase == PH_NORMAL || r_phase == PH_LINE) begin
                    o_res.kind = r_started ? KIND_DONE : KIND_NOWORD;
                end else begin
                    o_res.kind = KIND_BADCOM;
                end
            end else begin
                n_pos     = r_pos + 1'b1;
                o_res.pos = 32'(n_pos);
                case (r_phase)
                    PH_SLASH: begin
                        if (i_byte == CH_STAR) begin
                            n_phase = PH_BLOCK;
                        end else if (i_byte == CH_SLASH) begin
                            n_phase = PH_LINE;
                        end else begin
                            o_push     = 1'b1;
                            o_res.kind = KIND_BADCOM;
                        end
                    end
                    PH_BLOCK: begin
                        if (i_byte == CH_STAR) n_phase = PH_BSTAR;
                    end
                    PH_BSTAR: begin
                        // a run of stars keeps the closer armed
                        if (i_byte == CH_SLASH) begin
                            n_phase = PH_NORMAL;
                        end else if (i_byte != CH_STAR) begin
                            n_phase = PH_BLOCK;
                        end
                    end
                    PH_LINE: begin
                        if (i_byte == CH_LF) n_phase = PH_NORMAL;
                    end
                    default: begin
                        n_phase = PH_NORMAL;
                        if (w_space) begin
                            if (r_started) begin
                                o_push     = 1'b1;
                                o_res.kind = KIND_DONE;
                            end
                        end else if (i_byte == CH_SLASH) begin
                            n_phase = PH_SLASH;
                        end else if (w_fits) begin
                            n_started  = 1'b1;
                            n_count    = r_count + 9'd1;
                            o_push     = 1'b1;
                            o_res.kind = KIND_CHAR;
                            o_res.ch   = i_byte;
                            o_res.len  = n_count;
                        end else begin
                            o_push     = 1'b1;
                            o_res.kind = KIND_LONG;
                        end
                    end
                endcase
            end
            // every ending returns to skipping
            if (o_push && o_res.kind != KIND_CHAR) begin
                n_phase   = PH_NORMAL;
                n_started = 1'b0;
                n_count   = 9'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= WLC_MAX_LEN_RESET;
            r_phase   <= PH_NORMAL;
            r_started <= 1'b0;
            r_count   <= 9'd0;
            r_pos     <= '0;
        end else begin
            if (i_cfg_valid) r_max_len <= i_cfg_data;
            r_phase   <= n_phase;
            r_started <= n_started;
            r_count   <= n_count;
            r_pos     <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wlc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wlc_queue
    import wlc_pkg::*;
#(
    parameter int DEPTH = WLC_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_res        i_res,
    input  wire         i_pop,
    output t_res        o_res,
    output t_q_status   o_status
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    t_res               r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntBits-1:0] r_cnt;
    logic               w_push, w_pop;

    assign o_status.full  = (r_cnt == CntBits'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_res  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wlc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wlc_back
    import wlc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_q_status   i_q_status,
    input  t_res        i_res,
    output logic        o_pop,
    input  wire         i_ready,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [55:0] o_data
);

    logic r_valid;
    t_res r_res;

    // reload the output stage whenever it is empty or being drained
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_res;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_res.kind;
    assign o_data  = {7'd0, r_res.pos, r_res.len, r_res.ch};

endmodule

`default_nettype wire

FILE: hw/rtl/word_lexer_with_comments.sv
// Channel      Direction  Handshake                     Payload
// config       in         i_cfg_valid / o_cfg_ready     i_cfg_data = max_word_length
// char stream  in         s_axis_tvalid / tready        tdata = in_byte, tuser = end_of_input
// results      out        m_axis_tvalid / tready        tdata = char, length, position
//
// One item per cycle is accepted while the result queue has room; the lexer state update
// in the front stage is registered once per accepted item, so consecutive items follow back to back.
// A result, where an item gives one, is written into the queue and then loaded into the output register.
// Reset (synchronous, active low) returns to skipping, clears counts and the queue,
// and sets max_word_length to 64. A stalled output fills the four-entry queue, then
// s_axis_tready drops. o_cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "word_lexer_with_comments_assert.svh"

module word_lexer_with_comments
    import wlc_pkg::*;
#(
    parameter int POSITION_BITS = WLC_POSITION_BITS,
    parameter int QUEUE_DEPTH   = WLC_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [8:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire  [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] out_char, [16:8] word_length, [48:17] byte_position
    output logic [2:0]  m_axis_tuser    // [2:0] result_kind
);

    t_q_status w_q_status;
    t_res      w_push_res, w_head_res;
    logic      w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    wlc_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .i_eoi      (s_axis_tuser[0]),
        .i_q_status (w_q_status),
        .o_ready    (s_axis_tready),
        .o_push     (w_push),
        .o_res      (w_push_res)
    );

    wlc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_push_res),
        .i_pop   (w_pop),
        .o_res   (w_head_res),
        .o_status(w_q_status)
    );

    wlc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(w_q_status),
        .i_res     (w_head_res),
        .o_pop     (w_pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_kind    (m_axis_tuser),
        .o_data    (m_axis_tdata)
    );

    // a passed-out character always counts itself
    `WLC_ASSERT_IMPL(a_char_len, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_CHAR, m_axis_tdata[16:8] != 9'd0)
    // endings carry no character
    `WLC_ASSERT_IMPL(a_end_nochar, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser != KIND_CHAR, m_axis_tdata[7:0] == 8'd0)
    // an accepted end mark always leaves a result queued
    `WLC_ASSERT_NEXT(a_eoi_queued, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !w_q_status.empty)
    // the front never pushes into a full queue
    `WLC_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full)

endmodule

`default_nettype wire

FILE: test/tb_word_lexer_with_comments.sv
`timescale 1ns / 1ps

module tb_word_lexer_with_comments;
    import wlc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int QUIET_FROM   = 500;   // no idling on either side past this many items
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic [0:0]  s_axis_tuser;   // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [7:0] out_char, [16:8] word_length, [48:17] byte_position
    logic [2:0]  m_axis_tuser;   // [2:0] result_kind

    int sent;        // items accepted, counted by the driver
    int in_count;    // items accepted, counted by the monitor
    int eff_limit;   // buffer size in use, for shaping word lengths

    word_lexer_with_comments dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    class lexer_scoreboard;
        t_res        pending_tokens[$];
        int          errors;
        t_phase      phase;
        bit          in_word;
        logic [8:0]  chars;
        logic [31:0] bytes_seen;
        logic [8:0]  max_len;

        function new();
            errors     = 0;
            phase      = PH_NORMAL;
            in_word    = 1'b0;
            chars      = '0;
            bytes_seen = '0;
            max_len    = WLC_MAX_LEN_RESET;
        endfunction

        static function bit is_blank(logic [7:0] b);
            return b == CH_NUL || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
        endfunction

        function void set_max_len(logic [8:0] v);
            max_len = v;
        endfunction

        function void end_word(t_kind k);
            t_res r;
            r.kind = k;
            r.ch   = '0;
            r.len  = chars;
            r.pos  = bytes_seen;
            pending_tokens.push_back(r);
            phase   = PH_NORMAL;
            in_word = 1'b0;
            chars   = '0;
        endfunction

        // one accepted input transaction; queues the token it produces, if any
        function void note_input(logic [7:0] b, logic eoi);
            int   lim;
            t_res r;
            if (eoi) begin
                if (phase == PH_NORMAL || phase == PH_LINE)
                    end_word(in_word ? KIND_DONE : KIND_NOWORD);
                else
                    end_word(KIND_BADCOM);
                return;
            end
            bytes_seen++;
            case (phase)
                PH_SLASH: begin
                    if (b == CH_STAR)
                        phase = PH_BLOCK;
                    else if (b == CH_SLASH)
                        phase = PH_LINE;
                    else
                        end_word(KIND_BADCOM);
                    return;
                end
                PH_BLOCK: begin
                    if (b == CH_STAR)
                        phase = PH_BSTAR;
                    return;
                end
                PH_BSTAR: begin
                    if (b == CH_SLASH)
                        phase = PH_NORMAL;
                    else if (b != CH_STAR)
                        phase = PH_BLOCK;
                    return;
                end
                PH_LINE: begin
                    if (b == CH_LF)
                        phase = PH_NORMAL;
                    return;
                end
                default: ;
            endcase
            if (is_blank(b)) begin
                if (in_word)
                    end_word(KIND_DONE);
                return;
            end
            if (b == CH_SLASH) begin
                phase = PH_SLASH;
                return;
            end
            in_word = 1'b1;
            lim = (max_len > WLC_LENGTH_LIMIT) ? WLC_LENGTH_LIMIT : int'(max_len);
            if (lim >= 2 && int'(chars) < lim - 1) begin
                chars++;
                r.kind = KIND_CHAR;
                r.ch   = b;
                r.len  = chars;
                r.pos  = bytes_seen;
                pending_tokens.push_back(r);
            end else begin
                end_word(KIND_LONG);
            end
        endfunction

        function void check_token(logic [2:0] kind, logic [7:0] ch, logic [8:0] len,
                                  logic [31:0] pos);
            t_res exp;
            if (pending_tokens.size() == 0) begin
                $error("unexpected token: result_kind %0d out_char %0d word_length %0d",
                       kind, ch, len);
                errors++;
                return;
            end
            exp = pending_tokens.pop_front();
            if (kind !== exp.kind) begin
                $error("result_kind: expected %0d, actual %0d", exp.kind, kind);
                errors++;
            end
            if (ch !== exp.ch) begin
                $error("out_char: expected %0d, actual %0d", exp.ch, ch);
                errors++;
            end
            if (len !== exp.len) begin
                $error("word_length: expected %0d, actual %0d", exp.len, len);
                errors++;
            end
            if (pos !== exp.pos) begin
                $error("byte_position: expected %0d, actual %0d", exp.pos, pos);
                errors++;
            end
        endfunction
    endclass

    lexer_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor: every transaction is taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_max_len(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_input(s_axis_tdata, s_axis_tuser[0]);
                in_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_token(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8],
                               m_axis_tdata[48:17]);
        end
    end

    // result sink: random stalls plus two long hold-offs to back the queue up
    initial begin : result_sink
        int n;
        int holds_done;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holds_done < 2 && in_count >= (holds_done == 0 ? 60 : 300)) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (in_count < QUIET_FROM && (in_count / 50) % 3 != 1 &&
                         $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (lexer_scoreboard::is_blank(b) || b == CH_SLASH);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 4))
            0:       return CH_NUL;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // starts at a falling edge, returns at the rising edge where the transaction lands
    task automatic push_item(input logic [7:0] b, input logic eoi);
        @(negedge i_clk);
        if (sent < QUIET_FROM && (sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    // only while idle: no tokens outstanding and the pipeline has had time to settle
    task automatic write_max_len(input logic [8:0] v);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        eff_limit = (v > WLC_LENGTH_LIMIT) ? WLC_LENGTH_LIMIT : int'(v);
    endtask

    task automatic send_chunk();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // word; lengths around the limit when the buffer is small
            if (eff_limit <= 20)
                n = $urandom_range(1, eff_limit + 1);
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(11, 40);
            else
                n = $urandom_range(1, 10);
            repeat (n) push_item(word_byte(), 1'b0);
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 3)) push_item(blank_byte(), 1'b0);
        end else if (pick < 75) begin
            // block comment, closed by one or more stars and a slash
            push_item(CH_SLASH, 1'b0);
            push_item(CH_STAR, 1'b0);
            repeat ($urandom_range(0, 6)) push_item(8'($urandom_range(0, 255)), 1'b0);
            repeat ($urandom_range(1, 3)) push_item(CH_STAR, 1'b0);
            push_item(CH_SLASH, 1'b0);
        end else if (pick < 83) begin
            push_item(CH_SLASH, 1'b0);
            push_item(CH_SLASH, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                push_item(b == CH_LF ? CH_SPACE : b, 1'b0);
            end
            push_item(CH_LF, 1'b0);
        end else if (pick < 88) begin
            push_item(CH_SLASH, 1'b0);
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_STAR || b == CH_SLASH);
            push_item(b, 1'b0);
        end else if (pick < 92) begin
            // end of input, sometimes inside an unfinished comment
            case ($urandom_range(0, 3))
                0: push_item(CH_SLASH, 1'b0);
                1: begin
                    push_item(CH_SLASH, 1'b0);
                    push_item(CH_STAR, 1'b0);
                end
                2: begin
                    push_item(CH_SLASH, 1'b0);
                    push_item(CH_SLASH, 1'b0);
                end
                default: ;
            endcase
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            push_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_chunks(input int n);
        int start;
        start = sent;
        while (sent - start < n) send_chunk();
    endtask

    initial begin : stimulus
        logic [8:0] script[$];
        sent          = 0;
        in_count      = 0;
        eff_limit     = int'(WLC_MAX_LEN_RESET);
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        script = '{
            {1'b1, 8'hFF},                                  // end with no word
            {1'b0, CH_SPACE}, {1'b0, CH_TAB},
            {1'b0, 8'h01}, {1'b0, 8'hFF}, {1'b0, 8'h80},
            {1'b0, CH_NUL},                                 // NUL ends the word
            {1'b0, 8'h78}, {1'b0, CH_SLASH}, {1'b0, CH_STAR},
            {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
            {1'b0, CH_CR},
            {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_LF}, {1'b1, 8'h00},
            {1'b0, CH_SLASH}, {1'b0, 8'h61},                // stray slash
            {1'b0, CH_SLASH}, {1'b1, 8'h00},
            {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b1, 8'h00}
        };
        foreach (script[k]) push_item(script[k][7:0], script[k][8]);

        write_max_len(9'd2);
        send_chunks(35);
        write_max_len(9'd0);
        send_chunks(20);
        write_max_len(9'd1);
        send_chunks(20);
        write_max_len(9'd3);
        send_chunks(35);
        // all ones: clamped to the length limit; one word runs past it
        write_max_len(9'h1FF);
        repeat (WLC_LENGTH_LIMIT + 1) push_item(word_byte(), 1'b0);
        push_item(CH_SPACE, 1'b0);
        send_chunks(5);
        write_max_len(9'd256);
        send_chunks(35);
        write_max_len(9'd17);
        send_chunks(40);
        write_max_len(9'($urandom_range(0, 511)));
        send_chunks(35);
        write_max_len(WLC_MAX_LEN_RESET);
        send_chunks(55);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
